FILE: rtl/skinpc_pkg.sv
// Shared types and constants for the skin pixel classifier.
`default_nettype none

package skinpc_pkg;

  localparam int unsigned PIX_W   = 24;
  localparam int unsigned CFG_AW  = 4;
  localparam int unsigned CFG_DW  = 8;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_sel_e;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_HUE_HIGH  = 4'd0;
  localparam logic [CFG_AW-1:0] REG_SAT_LOW   = 4'd1;
  localparam logic [CFG_AW-1:0] REG_SAT_HIGH  = 4'd2;
  localparam logic [CFG_AW-1:0] REG_RED_MIN   = 4'd3;
  localparam logic [CFG_AW-1:0] REG_GREEN_MIN = 4'd4;
  localparam logic [CFG_AW-1:0] REG_BLUE_MIN  = 4'd5;
  localparam logic [CFG_AW-1:0] REG_RG_GAP    = 4'd6;
  localparam logic [CFG_AW-1:0] REG_LUMA_MIN  = 4'd7;

  // reset values
  localparam logic [7:0] RST_HUE_HIGH  = 8'd50;
  localparam logic [7:0] RST_SAT_LOW   = 8'd30;
  localparam logic [7:0] RST_SAT_HIGH  = 8'd150;
  localparam logic [7:0] RST_RED_MIN   = 8'd95;
  localparam logic [7:0] RST_GREEN_MIN = 8'd40;
  localparam logic [7:0] RST_BLUE_MIN  = 8'd20;
  localparam logic [7:0] RST_RG_GAP    = 8'd15;
  localparam logic [7:0] RST_LUMA_MIN  = 8'd80;

  // reciprocal table scaling
  localparam int unsigned REC_SHIFT = 17;
  localparam int unsigned REC_W     = REC_SHIFT + 1;

  // luma, Q14
  localparam int unsigned Y_W      = 22;
  localparam logic [Y_W-1:0] Y_CR  = 22'd4899;
  localparam logic [Y_W-1:0] Y_CG  = 22'd9617;
  localparam logic [Y_W-1:0] Y_CB  = 22'd1868;
  localparam logic [Y_W-1:0] Y_RND = 22'd8192;
  localparam int unsigned Y_SHIFT  = 14;

  // chroma, Q14
  localparam int unsigned CHR_W = 24;
  localparam logic signed [CHR_W-1:0] CR_COEF  = 24'sd11682;
  localparam logic signed [CHR_W-1:0] CB_COEF  = 24'sd9241;
  localparam logic signed [CHR_W-1:0] CHR_BIAS = 24'sd2105344;

  localparam logic [7:0] CR_MIN   = 8'd135;
  localparam logic [7:0] CB_MIN   = 8'd85;
  localparam logic [8:0] HUE_WRAP = 9'd180;
  localparam logic [8:0] HUE_RAW_LIMIT = 9'd360;

  // decimal constant in units of 1e-4, rounded to the given fraction bits
  function automatic longint qdec(input longint n, input int unsigned frac);
    return ((n <<< frac) + 64'sd5000) / 10000;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/skin_pixel_classifier_core.sv
// Skin pixel classifier: seven-stage pipeline from BGR pixel to masked pixel and flag.
// Each item passes through seven stage registers from input accept to output valid.
// Throughput: one item per cycle; each stage holds while it is full and the next one stalls.
// Hue, saturation divides: 256-entry reciprocal table, multiply, back-multiply, correction.
// Reset clears all stage valid bits and loads the threshold registers with their defaults.
// Config port is always ready; each write is registered into its threshold register.
`default_nettype none

module skin_pixel_classifier_core #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [skinpc_pkg::PIX_W-1:0]      s_axis_tdata,   // blue, green, red
  input  wire logic                              s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [skinpc_pkg::PIX_W-1:0]           m_axis_tdata,   // blue, green, red
  output logic                                   m_axis_tuser,   // skin
  output logic                                   m_axis_tlast,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [skinpc_pkg::CFG_AW-1:0]     cfg_index_i,
  input  wire logic [skinpc_pkg::CFG_DW-1:0]     cfg_data_i
);
  import skinpc_pkg::*;

  localparam int unsigned NSTG = 7;
  localparam int unsigned LW   = FRAC_BITS + 13;
  localparam longint unsigned REC_ONE = 64'd1 << REC_SHIFT;

  localparam logic signed [LW-1:0] BND_A [5] = '{
    LW'(qdec(15862, FRAC_BITS)),
    LW'(qdec(3448, FRAC_BITS)),
    LW'(-qdec(45652, FRAC_BITS)),
    LW'(-qdec(11500, FRAC_BITS)),
    LW'(-qdec(22857, FRAC_BITS))
  };
  localparam logic signed [LW-1:0] BND_B [5] = '{
    LW'(longint'(20) <<< FRAC_BITS),
    LW'(qdec(762069, FRAC_BITS)),
    LW'(qdec(2345652, FRAC_BITS)),
    LW'(qdec(3017500, FRAC_BITS)),
    LW'(qdec(4328500, FRAC_BITS))
  };
  // 1: upper bound (lhs <= rhs), 0: lower bound
  localparam logic [4:0] BND_UPPER = 5'b11001;

  // ---------------- configuration ----------------
  logic [7:0] hue_high_q, sat_low_q, sat_high_q, red_min_q;
  logic [7:0] green_min_q, blue_min_q, rg_gap_q, luma_min_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_high_q  <= RST_HUE_HIGH;
      sat_low_q   <= RST_SAT_LOW;
      sat_high_q  <= RST_SAT_HIGH;
      red_min_q   <= RST_RED_MIN;
      green_min_q <= RST_GREEN_MIN;
      blue_min_q  <= RST_BLUE_MIN;
      rg_gap_q    <= RST_RG_GAP;
      luma_min_q  <= RST_LUMA_MIN;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_HUE_HIGH:  hue_high_q  <= cfg_data_i;
        REG_SAT_LOW:   sat_low_q   <= cfg_data_i;
        REG_SAT_HIGH:  sat_high_q  <= cfg_data_i;
        REG_RED_MIN:   red_min_q   <= cfg_data_i;
        REG_GREEN_MIN: green_min_q <= cfg_data_i;
        REG_BLUE_MIN:  blue_min_q  <= cfg_data_i;
        REG_RG_GAP:    rg_gap_q    <= cfg_data_i;
        REG_LUMA_MIN:  luma_min_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- reciprocal table ----------------
  logic [REC_W-1:0] rec_tab [256];

  assign rec_tab[0] = '0;
  for (genvar i = 1; i < 256; i++) begin : g_rec
    localparam longint unsigned RV = REC_ONE / i;
    assign rec_tab[i] = REC_W'(RV);
  end

  // ---------------- flow control ----------------
  logic [NSTG:1]   vld_q;
  logic [NSTG+1:1] rdy;

  always_comb begin
    rdy[NSTG+1] = m_axis_tready;
    for (int k = NSTG; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[1]) vld_q[1] <= s_axis_tvalid;
      for (int k = 2; k <= NSTG; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // ---------------- stage 1: input register ----------------
  pix_t pix1_q;
  logic last1_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      pix1_q  <= pix_t'(s_axis_tdata);
      last1_q <= s_axis_tlast;
    end
  end

  // ---------------- stage 2: max/min, luma, RGB rule ----------------
  logic [7:0]     vmax_d, vmin_d, gap_d;
  max_sel_e       sel_d;
  logic [Y_W-1:0] ysum_d;
  logic           rgb_d;

  always_comb begin
    if (pix1_q.red >= pix1_q.green && pix1_q.red >= pix1_q.blue) begin
      sel_d  = MAX_RED;
      vmax_d = pix1_q.red;
    end else if (pix1_q.green >= pix1_q.blue) begin
      sel_d  = MAX_GREEN;
      vmax_d = pix1_q.green;
    end else begin
      sel_d  = MAX_BLUE;
      vmax_d = pix1_q.blue;
    end
    vmin_d = pix1_q.red;
    if (pix1_q.green < vmin_d) vmin_d = pix1_q.green;
    if (pix1_q.blue < vmin_d) vmin_d = pix1_q.blue;
    ysum_d = Y_CR * Y_W'(pix1_q.red) + Y_CG * Y_W'(pix1_q.green)
           + Y_CB * Y_W'(pix1_q.blue) + Y_RND;
    gap_d  = (pix1_q.red >= pix1_q.green) ? pix1_q.red - pix1_q.green
                                          : pix1_q.green - pix1_q.red;
    rgb_d  = pix1_q.red > red_min_q && pix1_q.green > green_min_q &&
             pix1_q.blue > blue_min_q && pix1_q.red > pix1_q.green &&
             pix1_q.red > pix1_q.blue && gap_d > rg_gap_q;
  end

  pix_t     pix2_q;
  logic     last2_q, rgb2_q;
  logic [7:0] vmax2_q, d2_q, y2_q;
  max_sel_e sel2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      pix2_q  <= pix1_q;
      last2_q <= last1_q;
      vmax2_q <= vmax_d;
      d2_q    <= vmax_d - vmin_d;
      sel2_q  <= sel_d;
      y2_q    <= ysum_d[Y_SHIFT +: 8];
      rgb2_q  <= rgb_d;
    end
  end

  // ---------------- stage 3: dividends, chroma products ----------------
  logic [11:0]             t_d;
  logic [15:0]             ns_d;
  logic [17:0]             nh_full_d;
  logic signed [8:0]       rdiff_d, bdiff_d;
  logic signed [CHR_W-1:0] crp_d, cbp_d;

  always_comb begin
    case (sel2_q)
      MAX_RED:   t_d = 12'(pix2_q.green) - 12'(pix2_q.blue) + 12'(d2_q) * 12'd6;
      MAX_GREEN: t_d = 12'(pix2_q.blue) - 12'(pix2_q.red) + 12'(d2_q) * 12'd8;
      MAX_BLUE:  t_d = 12'(pix2_q.red) - 12'(pix2_q.green) + 12'(d2_q) * 12'd10;
      default:   t_d = '0;
    endcase
    ns_d      = 16'(d2_q) * 16'd255 + 16'(vmax2_q[7:1]);
    nh_full_d = 18'(t_d) * 18'd60 + 18'(d2_q);
    rdiff_d   = signed'({1'b0, pix2_q.red}) - signed'({1'b0, y2_q});
    bdiff_d   = signed'({1'b0, pix2_q.blue}) - signed'({1'b0, y2_q});
    crp_d     = CHR_W'(rdiff_d) * CR_COEF + CHR_BIAS;
    cbp_d     = CHR_W'(bdiff_d) * CB_COEF + CHR_BIAS;
  end

  pix_t                    pix3_q;
  logic                    last3_q, rgb3_q;
  logic [7:0]              vmax3_q, d3_q, y3_q;
  logic [15:0]             ns3_q;
  logic [16:0]             nh3_q;
  logic signed [CHR_W-1:0] crp3_q, cbp3_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      pix3_q  <= pix2_q;
      last3_q <= last2_q;
      rgb3_q  <= rgb2_q;
      vmax3_q <= vmax2_q;
      d3_q    <= d2_q;
      y3_q    <= y2_q;
      ns3_q   <= ns_d;
      nh3_q   <= nh_full_d[17:1];
      crp3_q  <= crp_d;
      cbp3_q  <= cbp_d;
    end
  end

  // ---------------- stage 4: reciprocal multiply, chroma clamp ----------------
  logic [33:0] ps_d;
  logic [34:0] ph_d;
  logic [7:0]  cr_d, cb_d;

  always_comb begin
    ps_d = 34'(ns3_q) * 34'(rec_tab[vmax3_q]);
    ph_d = 35'(nh3_q) * 35'(rec_tab[d3_q]);
    if (crp3_q < 0) cr_d = '0;
    else if (crp3_q[CHR_W-1:Y_SHIFT] > 10'd255) cr_d = 8'd255;
    else cr_d = crp3_q[Y_SHIFT +: 8];
    if (cbp3_q < 0) cb_d = '0;
    else if (cbp3_q[CHR_W-1:Y_SHIFT] > 10'd255) cb_d = 8'd255;
    else cb_d = cbp3_q[Y_SHIFT +: 8];
  end

  pix_t        pix4_q;
  logic        last4_q, rgb4_q;
  logic [7:0]  vmax4_q, d4_q, y4_q, qs4_q, cr4_q, cb4_q;
  logic [8:0]  qh4_q;
  logic [15:0] ns4_q;
  logic [16:0] nh4_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      pix4_q  <= pix3_q;
      last4_q <= last3_q;
      rgb4_q  <= rgb3_q;
      vmax4_q <= vmax3_q;
      d4_q    <= d3_q;
      y4_q    <= y3_q;
      ns4_q   <= ns3_q;
      nh4_q   <= nh3_q;
      qs4_q   <= ps_d[REC_SHIFT +: 8];
      qh4_q   <= ph_d[REC_SHIFT +: 9];
      cr4_q   <= cr_d;
      cb4_q   <= cb_d;
    end
  end

  // ---------------- stage 5: back-multiply, chroma line products ----------------
  logic signed [LW-1:0] cbx_d;
  logic signed [LW-1:0] bp_d [5];
  logic                 chb_d;

  always_comb begin
    cbx_d = signed'(LW'(cb4_q));
    for (int i = 0; i < 5; i++) begin
      bp_d[i] = BND_A[i] * cbx_d + BND_B[i];
    end
    chb_d = cr4_q > CR_MIN && cb4_q > CB_MIN && y4_q > luma_min_q;
  end

  pix_t                 pix5_q;
  logic                 last5_q, rgb5_q, chb5_q;
  logic [7:0]           vmax5_q, d5_q, qs5_q;
  logic [8:0]           qh5_q;
  logic [15:0]          ns5_q, ms5_q;
  logic [16:0]          nh5_q, mh5_q;
  logic signed [LW-1:0] lhs5_q;
  logic signed [LW-1:0] bp5_q [5];

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      pix5_q  <= pix4_q;
      last5_q <= last4_q;
      rgb5_q  <= rgb4_q;
      chb5_q  <= chb_d;
      vmax5_q <= vmax4_q;
      d5_q    <= d4_q;
      qs5_q   <= qs4_q;
      qh5_q   <= qh4_q;
      ns5_q   <= ns4_q;
      nh5_q   <= nh4_q;
      ms5_q   <= 16'(qs4_q) * 16'(vmax4_q);
      mh5_q   <= 17'(qh4_q) * 17'(d4_q);
      lhs5_q  <= signed'(LW'(cr4_q) << FRAC_BITS);
      for (int i = 0; i < 5; i++) begin
        bp5_q[i] <= bp_d[i];
      end
    end
  end

  // ---------------- stage 6: quotient correction, chroma bounds ----------------
  logic [15:0] rs_d;
  logic [16:0] rh_d;
  logic [7:0]  sat_d;
  logic [8:0]  hraw_d;
  logic [4:0]  bnd_ok_d;

  always_comb begin
    rs_d   = ns5_q - ms5_q;
    rh_d   = nh5_q - mh5_q;
    sat_d  = (vmax5_q != '0 && rs_d >= 16'(vmax5_q)) ? qs5_q + 8'd1 : qs5_q;
    hraw_d = (d5_q != '0 && rh_d >= 17'(d5_q)) ? qh5_q + 9'd1 : qh5_q;
    for (int i = 0; i < 5; i++) begin
      bnd_ok_d[i] = BND_UPPER[i] ? (lhs5_q <= bp5_q[i]) : (lhs5_q >= bp5_q[i]);
    end
  end

  pix_t       pix6_q;
  logic       last6_q, rgb6_q, ch6_q;
  logic [7:0] sat6_q;
  logic [8:0] hraw6_q;

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      pix6_q  <= pix5_q;
      last6_q <= last5_q;
      rgb6_q  <= rgb5_q;
      ch6_q   <= chb5_q && (&bnd_ok_d);
      sat6_q  <= sat_d;
      hraw6_q <= hraw_d;
    end
  end

  // ---------------- stage 7: hue wrap, decision, output register ----------------
  logic [7:0] hue_d;
  logic       hs_d, skin_d;

  always_comb begin
    hue_d  = (hraw6_q >= HUE_WRAP) ? 8'(hraw6_q - HUE_WRAP) : hraw6_q[7:0];
    hs_d   = hue_d <= hue_high_q && sat6_q >= sat_low_q && sat6_q <= sat_high_q;
    skin_d = rgb6_q && (hs_d || ch6_q);
  end

  pix_t pix7_q;
  logic skin7_q, last7_q;

  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      pix7_q  <= skin_d ? pix6_q : '0;
      skin7_q <= skin_d;
      last7_q <= last6_q;
    end
  end

  assign m_axis_tvalid = vld_q[NSTG];
  assign m_axis_tdata  = pix7_q;
  assign m_axis_tuser  = skin7_q;
  assign m_axis_tlast  = last7_q;

  // ---------------- assertions ----------------
  a_sat_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[5] && vmax5_q != '0 |-> rs_d < 16'(vmax5_q) + 16'(vmax5_q))
    else $error("saturation remainder out of correction range");

  a_hue_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[5] && d5_q != '0 |-> rh_d < 17'(d5_q) + 17'(d5_q))
    else $error("hue remainder out of correction range");

  a_hue_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[6] |-> hraw6_q < HUE_RAW_LIMIT)
    else $error("raw hue beyond one wrap");

  a_skin_rgb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[23:16] > m_axis_tdata[15:8] && m_axis_tdata[23:16] > m_axis_tdata[7:0])
    else $error("skin item fails red dominance");

  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("non-skin item not blanked");

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Testbench for skin_pixel_classifier_core: directed and random pixels, scored by a predictor.
`default_nettype none

module tb;
  import skinpc_pkg::*;

  localparam int unsigned FRAC      = 14;
  localparam int unsigned LIMIT     = 400000;
  localparam int unsigned PHASE_LEN = 280;
  localparam logic [CFG_AW-1:0] REG_SPARE_FIRST = 4'd8;
  localparam logic [CFG_AW-1:0] REG_SPARE_LAST  = 4'd15;

  typedef struct {
    pix_t pix;
    logic skin;
    logic last;
  } pix_verdict_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [PIX_W-1:0]   s_axis_tdata;   // blue, green, red
  logic               s_axis_tlast;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [PIX_W-1:0]   m_axis_tdata;   // blue, green, red
  logic               m_axis_tuser;   // skin
  logic               m_axis_tlast;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CFG_AW-1:0]  cfg_index_i;
  logic [CFG_DW-1:0]  cfg_data_i;

  logic [7:0]   thr [0:15];
  pix_verdict_t pending_pix [$];
  int unsigned  err_count;
  int unsigned  cycle_count;
  bit           quiet_tail;
  int           stall_left;
  int           calm_left;

  skin_pixel_classifier_core #(
    .FRAC_BITS(FRAC)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // decimal in units of 1e-4 to fixed point, halves rounded up (positive only)
  function automatic longint to_fixed(input longint dec4);
    return (dec4 * (64'sd1 <<< FRAC) + 64'sd5000) / 64'sd10000;
  endfunction

  function automatic longint clamp_chroma(input longint acc);
    longint v;
    if (acc < 0) return 0;
    v = acc >>> 14;
    return (v > 255) ? 255 : v;
  endfunction

  function automatic logic skin_verdict(input logic [7:0] bl, input logic [7:0] gr,
                                        input logic [7:0] rd);
    int b, g, r, vmax, vmin, d, s, h, num, y, gap;
    longint cr, cb, lhs;
    logic rgb_ok, hs_ok, ch_ok;
    b = int'(bl);
    g = int'(gr);
    r = int'(rd);
    vmax = (g > r) ? g : r;
    vmax = (b > vmax) ? b : vmax;
    vmin = (g < r) ? g : r;
    vmin = (b < vmin) ? b : vmin;
    d = vmax - vmin;
    s = (vmax == 0) ? 0 : (255 * d + vmax / 2) / vmax;
    if (d == 0) begin
      h = 0;
    end else begin
      if (vmax == r) num = g - b;
      else if (vmax == g) num = b - r + 2 * d;
      else num = r - g + 4 * d;
      h = (60 * (num + 6 * d) + d) / (2 * d);
      if (h >= 180) h -= 180;
    end
    y  = (4899 * r + 9617 * g + 1868 * b + 8192) >>> 14;
    cr = clamp_chroma(longint'(r - y) * 11682 + (64'sd128 <<< 14) + 8192);
    cb = clamp_chroma(longint'(b - y) * 9241 + (64'sd128 <<< 14) + 8192);
    gap = (r > g) ? r - g : g - r;
    rgb_ok = r > int'(thr[REG_RED_MIN]) && g > int'(thr[REG_GREEN_MIN]) &&
             b > int'(thr[REG_BLUE_MIN]) && r > g && r > b && gap > int'(thr[REG_RG_GAP]);
    hs_ok = h <= int'(thr[REG_HUE_HIGH]) && s >= int'(thr[REG_SAT_LOW]) &&
            s <= int'(thr[REG_SAT_HIGH]);
    lhs = cr <<< FRAC;
    ch_ok = cr > longint'(CR_MIN) && cb > longint'(CB_MIN) && y > int'(thr[REG_LUMA_MIN]) &&
            lhs <= to_fixed(15862) * cb + to_fixed(200000) &&
            lhs >= to_fixed(3448) * cb + to_fixed(762069) &&
            lhs >= -to_fixed(45652) * cb + to_fixed(2345652) &&
            lhs <= -to_fixed(11500) * cb + to_fixed(3017500) &&
            lhs <= -to_fixed(22857) * cb + to_fixed(4328500);
    return rgb_ok && (hs_ok || ch_ok);
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (err_count < 40)
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    err_count++;
  endtask

  task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                            input logic last);
    pix_verdict_t exp_item;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r, g, b};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    exp_item.skin      = skin_verdict(b, g, r);
    exp_item.pix.blue  = exp_item.skin ? b : 8'd0;
    exp_item.pix.green = exp_item.skin ? g : 8'd0;
    exp_item.pix.red   = exp_item.skin ? r : 8'd0;
    exp_item.last      = last;
    pending_pix.push_back(exp_item);
  endtask

  task automatic hold_input(input int cycles);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] idx, input logic [7:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx <= REG_LUMA_MIN) thr[idx] = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_thresholds(input logic [7:0] hue_hi, input logic [7:0] s_lo,
                                 input logic [7:0] s_hi, input logic [7:0] r_min,
                                 input logic [7:0] g_min, input logic [7:0] b_min,
                                 input logic [7:0] rg_gap, input logic [7:0] y_min);
    wait_drained();
    cfg_write(REG_HUE_HIGH, hue_hi);
    cfg_write(REG_SAT_LOW, s_lo);
    cfg_write(REG_SAT_HIGH, s_hi);
    cfg_write(REG_RED_MIN, r_min);
    cfg_write(REG_GREEN_MIN, g_min);
    cfg_write(REG_BLUE_MIN, b_min);
    cfg_write(REG_RG_GAP, rg_gap);
    cfg_write(REG_LUMA_MIN, y_min);
  endtask

  task automatic send_probes();
    send_pixel(8'd90, 8'd120, 8'd200, 1'b0);
    send_pixel(8'd70, 8'd70, 8'd70, 1'b0);
    send_pixel(8'd1, 8'd1, 8'd255, 1'b1);
  endtask

  // reset thresholds, channel extremes, black, grey, each max channel
  task automatic test_reset_defaults();
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd90, 8'd120, 8'd200, 1'b0);
    send_pixel(8'd120, 8'd150, 8'd220, 1'b1);
    send_pixel(8'd60, 8'd100, 8'd180, 1'b0);
    send_pixel(8'd21, 8'd41, 8'd96, 1'b0);
    send_pixel(8'd20, 8'd40, 8'd95, 1'b0);
    send_pixel(8'd100, 8'd160, 8'd250, 1'b1);
  endtask

  // extreme register settings, hue bound past the wrap, crossed saturation bounds
  task automatic test_register_extremes();
    load_thresholds(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_probes();
    load_thresholds(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_probes();
    load_thresholds(8'd179, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_probes();
    load_thresholds(8'd180, 8'd200, 8'd100, RST_RED_MIN, RST_GREEN_MIN, RST_BLUE_MIN,
                    RST_RG_GAP, RST_LUMA_MIN);
    send_probes();
    load_thresholds(RST_HUE_HIGH, RST_SAT_LOW, RST_SAT_HIGH, RST_RED_MIN, RST_GREEN_MIN,
                    RST_BLUE_MIN, RST_RG_GAP, RST_LUMA_MIN);
    // writes to unmapped indexes must leave the thresholds alone
    cfg_write(REG_SPARE_FIRST, 8'h00);
    cfg_write(REG_SPARE_LAST, 8'hff);
    send_probes();
  endtask

  task automatic test_random_frames();
    int          frame_left;
    bit          gappy;
    logic [7:0]  b, g, r;
    logic [23:0] raw;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: load_thresholds(RST_HUE_HIGH, RST_SAT_LOW, RST_SAT_HIGH, RST_RED_MIN,
                           RST_GREEN_MIN, RST_BLUE_MIN, RST_RG_GAP, RST_LUMA_MIN);
        2: load_thresholds(8'd180, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        default: load_thresholds(8'($urandom_range(0, 255)), 8'($urandom_range(0, 80)),
                                 8'($urandom_range(100, 255)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      quiet_tail = (phase == 5);
      frame_left = $urandom_range(1, 40);
      gappy = 1'b1;
      for (int n = 0; n < PHASE_LEN; n++) begin
        if ($urandom_range(0, 49) == 0) gappy = ~gappy;
        if (n == PHASE_LEN / 2) wait_drained();
        if ($urandom_range(0, 9) < 7) begin
          r = 8'($urandom_range(60, 255));
          g = 8'($urandom_range(20, r));
          b = 8'($urandom_range(10, r));
        end else begin
          raw = 24'($urandom);
          {r, g, b} = raw;
        end
        frame_left--;
        send_pixel(b, g, r, frame_left == 0);
        if (frame_left == 0) frame_left = $urandom_range(1, 40);
        if (!quiet_tail && gappy && $urandom_range(0, 2) == 0)
          hold_input($urandom_range(1, 6));
      end
    end
    wait_drained();
  endtask

  always @(negedge clk_i) begin
    if (quiet_tail) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (calm_left > 0) begin
      m_axis_tready <= 1'b1;
      calm_left--;
    end else if ($urandom_range(0, 1) == 1) begin
      stall_left = $urandom_range(1, 6) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      calm_left = $urandom_range(4, 30) - 1;
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    pix_verdict_t exp_item;
    pix_t         got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_pix.size() == 0) begin
        note_mismatch("unexpected item", 32'(m_axis_tdata), 32'd0);
      end else begin
        exp_item = pending_pix.pop_front();
        got = pix_t'(m_axis_tdata);
        if (got.blue !== exp_item.pix.blue)
          note_mismatch("blue", 32'(got.blue), 32'(exp_item.pix.blue));
        if (got.green !== exp_item.pix.green)
          note_mismatch("green", 32'(got.green), 32'(exp_item.pix.green));
        if (got.red !== exp_item.pix.red)
          note_mismatch("red", 32'(got.red), 32'(exp_item.pix.red));
        if (m_axis_tuser !== exp_item.skin)
          note_mismatch("skin", 32'(m_axis_tuser), 32'(exp_item.skin));
        if (m_axis_tlast !== exp_item.last)
          note_mismatch("last", 32'(m_axis_tlast), 32'(exp_item.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    err_count     = 0;
    cycle_count   = 0;
    quiet_tail    = 1'b0;
    stall_left    = 0;
    calm_left     = 0;
    thr[REG_HUE_HIGH]  = RST_HUE_HIGH;
    thr[REG_SAT_LOW]   = RST_SAT_LOW;
    thr[REG_SAT_HIGH]  = RST_SAT_HIGH;
    thr[REG_RED_MIN]   = RST_RED_MIN;
    thr[REG_GREEN_MIN] = RST_GREEN_MIN;
    thr[REG_BLUE_MIN]  = RST_BLUE_MIN;
    thr[REG_RG_GAP]    = RST_RG_GAP;
    thr[REG_LUMA_MIN]  = RST_LUMA_MIN;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_random_frames();

    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
